>>> sv/obte_pkg.sv
// Shared types and constants for the order book table engine.
// Depends on nothing. It is used by order_book_table_engine.
`timescale 1ns / 1ps
`default_nettype none
package obte_pkg;

   localparam int ORDER_SLOTS  = 4096;
   localparam int LEDGER_SLOTS = 4096;
   localparam int SCAN_SLOTS   = (ORDER_SLOTS > LEDGER_SLOTS) ? ORDER_SLOTS : LEDGER_SLOTS;
   localparam int ORDER_AW     = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
   localparam int LEDGER_AW    = (LEDGER_SLOTS > 1) ? $clog2(LEDGER_SLOTS) : 1;
   localparam int SCAN_CW      = $clog2(SCAN_SLOTS + 1);

   // Order word: valid, key, shares, price.
   localparam int ORDER_W  = 1 + 64 + 32 + 32;
   // Ledger word: valid, key, notional, shares.
   localparam int LEDGER_W = 1 + 64 + 64 + 64;

   localparam logic [2:0] OP_ADD      = 3'd0;
   localparam logic [2:0] OP_EXEC     = 3'd1;
   localparam logic [2:0] OP_EXEC_PX  = 3'd2;
   localparam logic [2:0] OP_CANCEL   = 3'd3;
   localparam logic [2:0] OP_DELETE   = 3'd4;
   localparam logic [2:0] OP_REPLACE  = 3'd5;

   localparam logic [2:0] STAT_OK          = 3'd0;
   localparam logic [2:0] STAT_NOT_FOUND   = 3'd1;
   localparam logic [2:0] STAT_DUPLICATE   = 3'd2;
   localparam logic [2:0] STAT_TABLE_FULL  = 3'd3;
   localparam logic [2:0] STAT_OVERFILL    = 3'd4;
   localparam logic [2:0] STAT_LEDGER_FULL = 3'd5;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_MUL,
      S_WRITE,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [2:0]  op;
      logic [63:0] order_ref;
      logic [63:0] new_order_ref;
      logic [31:0] share_count;
      logic [31:0] price_in;
      logic [63:0] match_id;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] order_price;
      logic [31:0] remaining_shares;
      logic        order_removed;
      logic [63:0] ledger_notional;
      logic [63:0] ledger_shares;
   } rsp_type;

endpackage
`default_nettype wire

>>> sv/obte_ram.sv
// Simple dual-port synchronous RAM with a registered read port.
// Generic; used for the order table and the ledger.
`timescale 1ns / 1ps
`default_nettype none
module obte_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

>>> sv/order_book_table_engine.sv
// Order book table engine: keyed order table plus per-match execution ledger.
// One request is taken at a time: req_ready is low from the request until the
// result moves to the output register. The linear scan of both memories, one entry
// a cycle through their single read ports, sets the time each request takes.
// Reset: a clearing pass of SCAN_SLOTS cycles zeroes both memories, with
// req_ready low until it ends. Depends on obte_pkg and obte_ram.
`timescale 1ns / 1ps
`default_nettype none
module order_book_table_engine
   import obte_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   // Control state.
   state_type            state_ff, state_in;
   logic [SCAN_CW-1:0]   cnt_ff;
   logic                 pend_ff;
   logic [SCAN_CW-1:0]   pend_idx_ff;
   logic                 rsp_valid_ff;

   // The request being worked on.
   req_type              req_ff;

   // Scan results. The order scan finds the first live entry with the
   // reference, whether the new reference is live, and the first free entry.
   logic                 o_hit_ff, n_hit_ff, o_free_ff;
   logic [ORDER_AW-1:0]  o_slot_ff, o_free_slot_ff;
   logic [31:0]          o_sh_ff, o_pr_ff;
   logic                 l_hit_ff, l_free_ff;
   logic [LEDGER_AW-1:0] l_slot_ff, l_free_slot_ff;
   logic [63:0]          l_not_ff, l_sh_ff;

   logic [63:0]          prod_ff;
   rsp_type              res_ff, res_in;
   rsp_type              rsp_ff;

   // Memory ports.
   logic                 o_we, l_we;
   logic [ORDER_AW-1:0]  o_wa;
   logic [LEDGER_AW-1:0] l_wa;
   logic [ORDER_W-1:0]   o_wd, o_rd;
   logic [LEDGER_W-1:0]  l_wd, l_rd;

   obte_ram #(.WIDTH(ORDER_W), .DEPTH(ORDER_SLOTS), .AW(ORDER_AW)) u_order_ram (
      .clock   (clock),
      .wr_en   (o_we),
      .wr_addr (o_wa),
      .wr_data (o_wd),
      .rd_addr (cnt_ff[ORDER_AW-1:0]),
      .rd_data (o_rd)
   );

   obte_ram #(.WIDTH(LEDGER_W), .DEPTH(LEDGER_SLOTS), .AW(LEDGER_AW)) u_ledger_ram (
      .clock   (clock),
      .wr_en   (l_we),
      .wr_addr (l_wa),
      .wr_data (l_wd),
      .rd_addr (cnt_ff[LEDGER_AW-1:0]),
      .rd_data (l_rd)
   );

   // Fields of the entries coming back from the memories.
   logic        rd_o_v, rd_l_v, o_in_rng, l_in_rng;
   logic [63:0] rd_o_key, rd_l_key;
   assign rd_o_v   = o_rd[ORDER_W-1];
   assign rd_o_key = o_rd[127:64];
   assign rd_l_v   = l_rd[LEDGER_W-1];
   assign rd_l_key = l_rd[191:128];
   // When the two memories differ in depth, entries past the smaller one's end
   // alias real entries and are ignored.
   assign o_in_rng = pend_ff && (pend_idx_ff < SCAN_CW'(ORDER_SLOTS));
   assign l_in_rng = pend_ff && (pend_idx_ff < SCAN_CW'(LEDGER_SLOTS));

   // Execution price and the ledger entry chosen for an execution.
   logic [31:0]  xp;
   assign xp = (req_ff.op == OP_EXEC) ? o_pr_ff : req_ff.price_in;

   logic [63:0] new_not, new_sh;
   logic [31:0] left;
   assign new_not = (l_hit_ff ? l_not_ff : 64'd0) + prod_ff;
   assign new_sh  = (l_hit_ff ? l_sh_ff : 64'd0) + {32'd0, req_ff.share_count};
   assign left    = o_sh_ff - req_ff.share_count;

   // Next state, memory writes and the result of the event.
   always_comb begin
      state_in = state_ff;
      o_we     = 1'b0;
      l_we     = 1'b0;
      o_wa     = cnt_ff[ORDER_AW-1:0];
      l_wa     = cnt_ff[LEDGER_AW-1:0];
      o_wd     = '0;
      l_wd     = '0;
      res_in   = '0;
      case (state_ff)
         S_CLEAR: begin
            o_we = cnt_ff < SCAN_CW'(ORDER_SLOTS);
            l_we = cnt_ff < SCAN_CW'(LEDGER_SLOTS);
            if (cnt_ff == SCAN_CW'(SCAN_SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // The last count issues no read and only drains the final entry.
            if (cnt_ff == SCAN_CW'(SCAN_SLOTS)) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            state_in = S_WRITE;
         end
         S_WRITE: begin
            state_in = S_DONE;
            case (req_ff.op)
               OP_ADD: begin
                  if (o_hit_ff) begin
                     res_in.status = STAT_DUPLICATE;
                  end else if (!o_free_ff) begin
                     res_in.status = STAT_TABLE_FULL;
                  end else begin
                     o_we = 1'b1;
                     o_wa = o_free_slot_ff;
                     o_wd = {1'b1, req_ff.order_ref, req_ff.share_count, req_ff.price_in};
                     res_in.order_price      = req_ff.price_in;
                     res_in.remaining_shares = req_ff.share_count;
                  end
               end
               OP_EXEC, OP_EXEC_PX, OP_CANCEL, OP_DELETE, OP_REPLACE: begin
                  o_wa = o_slot_ff;
                  l_wa = l_hit_ff ? l_slot_ff : l_free_slot_ff;
                  if (!o_hit_ff) begin
                     res_in.status = STAT_NOT_FOUND;
                  end else begin
                     res_in.order_price      = o_pr_ff;
                     res_in.remaining_shares = o_sh_ff;
                     if (req_ff.op == OP_DELETE) begin
                        o_we = 1'b1;
                        res_in.remaining_shares = 32'd0;
                        res_in.order_removed    = 1'b1;
                     end else if (req_ff.op == OP_REPLACE) begin
                        if (n_hit_ff) begin
                           res_in.status = STAT_DUPLICATE;
                        end else begin
                           o_we = 1'b1;
                           o_wd = {1'b1, req_ff.new_order_ref, req_ff.share_count,
                                   req_ff.price_in};
                           res_in.order_price      = req_ff.price_in;
                           res_in.remaining_shares = req_ff.share_count;
                        end
                     end else if (req_ff.share_count > o_sh_ff) begin
                        res_in.status = STAT_OVERFILL;
                     end else if (req_ff.op != OP_CANCEL && !l_hit_ff && !l_free_ff) begin
                        res_in.status = STAT_LEDGER_FULL;
                     end else begin
                        if (req_ff.op != OP_CANCEL) begin
                           l_we = 1'b1;
                           l_wd = {1'b1, req_ff.match_id, new_not, new_sh};
                           res_in.ledger_notional = new_not;
                           res_in.ledger_shares   = new_sh;
                        end
                        o_we = 1'b1;
                        res_in.remaining_shares = left;
                        if (left == 32'd0) begin
                           res_in.order_removed = 1'b1;
                        end else begin
                           o_wd = {1'b1, req_ff.order_ref, left, o_pr_ff};
                        end
                     end
                  end
               end
               default: begin
                  // Undefined operations give an all-zero result.
               end
            endcase
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Scan counter and read pipeline tracking.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= (state_ff == S_SCAN) && (cnt_ff != SCAN_CW'(SCAN_SLOTS));
         if (state_ff == S_CLEAR || state_ff == S_SCAN) begin
            cnt_ff <= (state_in == state_ff) ? cnt_ff + 1'b1 : '0;
         end else begin
            cnt_ff <= '0;
         end
      end
      pend_idx_ff <= cnt_ff;
   end

   // Request capture and scan bookkeeping.
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) begin
         req_ff    <= req_data;
         o_hit_ff  <= 1'b0;
         n_hit_ff  <= 1'b0;
         o_free_ff <= 1'b0;
         l_hit_ff  <= 1'b0;
         l_free_ff <= 1'b0;
      end else if (state_ff == S_SCAN) begin
         if (o_in_rng && rd_o_v && rd_o_key == req_ff.order_ref && !o_hit_ff) begin
            o_hit_ff  <= 1'b1;
            o_slot_ff <= pend_idx_ff[ORDER_AW-1:0];
            o_sh_ff   <= o_rd[63:32];
            o_pr_ff   <= o_rd[31:0];
         end
         if (o_in_rng && rd_o_v && rd_o_key == req_ff.new_order_ref) begin
            n_hit_ff <= 1'b1;
         end
         if (o_in_rng && !rd_o_v && !o_free_ff) begin
            o_free_ff      <= 1'b1;
            o_free_slot_ff <= pend_idx_ff[ORDER_AW-1:0];
         end
         if (l_in_rng && rd_l_v && rd_l_key == req_ff.match_id && !l_hit_ff) begin
            l_hit_ff  <= 1'b1;
            l_slot_ff <= pend_idx_ff[LEDGER_AW-1:0];
            l_not_ff  <= l_rd[127:64];
            l_sh_ff   <= l_rd[63:0];
         end
         if (l_in_rng && !rd_l_v && !l_free_ff) begin
            l_free_ff      <= 1'b1;
            l_free_slot_ff <= pend_idx_ff[LEDGER_AW-1:0];
         end
      end
      prod_ff <= {32'd0, xp} * {32'd0, req_ff.share_count};
      if (state_ff == S_WRITE) begin
         res_ff <= res_in;
      end
   end

   // Output register: the finished result waits here until it is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_DONE && (!rsp_valid_ff || rsp_ready)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (state_ff == S_DONE && (!rsp_valid_ff || rsp_ready)) begin
         rsp_ff <= res_ff;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Only one request is in flight at a time.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in flight");

   // The clearing pass keeps requests out after reset.
   a_clear_blocks: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request port open during clearing pass");

   // Ledger totals are reported only for a successful event.
   a_ledger_on_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STAT_OK |->
         rsp_data.ledger_notional == 64'd0 && rsp_data.ledger_shares == 64'd0)
      else $error("ledger totals on failed event");

   // A removed order has no shares left.
   a_removed_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.order_removed |->
         rsp_data.remaining_shares == 32'd0 && rsp_data.status == STAT_OK)
      else $error("removed order reports shares");

endmodule
`default_nettype wire
